// ----- sv/acs_pkg.sv -----
// ---------------------------------------------------------------------------
// acs_pkg: shared types and constants of the adaptive cutoff smoother
// Command and status types between controller and datapath, fixed-point
// constants and configuration register indexes.
// ---------------------------------------------------------------------------
package acs_pkg;

  // fraction bits of position and velocity
  localparam int FRAC_BITS_DEF = 16;

  // 2*pi in Q3.16, 0.01 in Q0.24, 1 Hz in Q.16, 1.0 in Q1.30
  localparam logic [18:0] TWO_PI_Q16    = 19'd411775;
  localparam logic [17:0] LAG_SCALE_Q24 = 18'd167772;
  localparam logic [16:0] ONE_HZ_Q16    = 17'd65536;
  localparam logic [30:0] ALPHA_ONE     = 31'h4000_0000;

  // register reset values
  localparam logic [15:0] JITTER_RST = 16'd205;
  localparam logic [15:0] LAG_RST    = 16'd205;
  localparam logic [15:0] PERIOD_RST = 16'd1966;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_JITTER = 2'd0,
    REG_LAG    = 2'd1,
    REG_PERIOD = 2'd2
  } reg_idx_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE  = 5'd0,
    OP_LOAD  = 5'd1,
    OP_START = 5'd2,
    OP_DIFF  = 5'd3,
    OP_VSAT  = 5'd4,
    OP_F1HZ  = 5'd5,
    OP_PMUL  = 5'd6,
    OP_WHI   = 5'd7,
    OP_WLO   = 5'd8,
    OP_WSUM  = 5'd9,
    OP_ALPHA = 5'd10,
    OP_VMUL  = 5'd11,
    OP_VUPD  = 5'd12,
    OP_LAGK  = 5'd13,
    OP_FMUL  = 5'd14,
    OP_FSET  = 5'd15,
    OP_PMULB = 5'd16,
    OP_PUPD  = 5'd17,
    OP_OUT   = 5'd18
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic upd;
    logic div_busy;
  } stat_t;

endpackage

// ----- sv/acs_if.sv -----
// ---------------------------------------------------------------------------
// acs_if: request and result channels of the adaptive cutoff smoother
// Valid/ready channels carrying one request or one filtered result.
// ---------------------------------------------------------------------------
interface acs_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] raw_x;
  logic signed [31:0] raw_y;
  logic signed [31:0] raw_z;

  modport source (output valid, req_type, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, req_type, raw_x, raw_y, raw_z, output ready);
endinterface

interface acs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] smooth_x;
  logic signed [31:0] smooth_y;
  logic signed [31:0] smooth_z;

  modport source (output valid, smooth_x, smooth_y, smooth_z, input ready);
  modport sink (input valid, smooth_x, smooth_y, smooth_z, output ready);
endinterface

// ----- sv/acs_div.sv -----
// ---------------------------------------------------------------------------
// acs_div: shared serial divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ---------------------------------------------------------------------------
module acs_div #(
  parameter int DVS_W = 54
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient
);
  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [5:0]       cnt;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // shift in next dividend bit and trial subtract
  assign rem_sh = {rem[DVS_W-1:0], quotient[63]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd63;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd0) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quotient <= {quotient[62:0], fits};
    end
  end
endmodule

// ----- sv/acs_ctrl.sv -----
// ---------------------------------------------------------------------------
// acs_ctrl: sequencer of the adaptive cutoff smoother
// Walks each update request through the three axes and issues datapath operations.
// ---------------------------------------------------------------------------
module acs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output acs_pkg::cmd_t cmd,
  input  acs_pkg::stat_t stat
);
  import acs_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_DISP  = 18'h00002,
    ST_DIFF  = 18'h00004,
    ST_VWAIT = 18'h00008,
    ST_F1HZ  = 18'h00010,
    ST_PMUL  = 18'h00020,
    ST_WHI   = 18'h00040,
    ST_WLO   = 18'h00080,
    ST_WSUM  = 18'h00100,
    ST_AWAIT = 18'h00200,
    ST_VMUL  = 18'h00400,
    ST_VUPD  = 18'h00800,
    ST_LAGK  = 18'h01000,
    ST_FMUL  = 18'h02000,
    ST_FSET  = 18'h04000,
    ST_PMULB = 18'h08000,
    ST_PUPD  = 18'h10000,
    ST_FIN   = 18'h20000
  } state_t;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic       phase, phase_next;
  logic       fin_fire;

  // next state and operation
  always_comb begin
    state_next = state;
    axis_next  = axis;
    phase_next = phase;
    cmd.op     = OP_NONE;
    cmd.axis   = axis;
    in_ready   = 1'b0;
    fin_fire   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          axis_next  = 2'd0;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (stat.upd) begin
          state_next = ST_DIFF;
        end else begin
          cmd.op     = OP_START;
          state_next = ST_FIN;
        end
      end
      ST_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_VSAT;
          state_next = ST_F1HZ;
        end
      end
      ST_F1HZ: begin
        cmd.op     = OP_F1HZ;
        phase_next = 1'b0;
        state_next = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.op     = OP_PMUL;
        state_next = ST_WHI;
      end
      ST_WHI: begin
        cmd.op     = OP_WHI;
        state_next = ST_WLO;
      end
      ST_WLO: begin
        cmd.op     = OP_WLO;
        state_next = ST_WSUM;
      end
      ST_WSUM: begin
        cmd.op     = OP_WSUM;
        state_next = ST_AWAIT;
      end
      ST_AWAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_ALPHA;
          state_next = phase ? ST_PMULB : ST_VMUL;
        end
      end
      ST_VMUL: begin
        cmd.op     = OP_VMUL;
        state_next = ST_VUPD;
      end
      ST_VUPD: begin
        cmd.op     = OP_VUPD;
        state_next = ST_LAGK;
      end
      ST_LAGK: begin
        cmd.op     = OP_LAGK;
        state_next = ST_FMUL;
      end
      ST_FMUL: begin
        cmd.op     = OP_FMUL;
        state_next = ST_FSET;
      end
      ST_FSET: begin
        cmd.op     = OP_FSET;
        phase_next = 1'b1;
        state_next = ST_PMUL;
      end
      ST_PMULB: begin
        cmd.op     = OP_PMULB;
        state_next = ST_PUPD;
      end
      ST_PUPD: begin
        cmd.op = OP_PUPD;
        if (axis == 2'd2) begin
          state_next = ST_FIN;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_DIFF;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT;
          fin_fire   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 2'd0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      phase <= phase_next;
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ----- sv/acs_dp.sv -----
// ---------------------------------------------------------------------------
// acs_dp: datapath of the adaptive cutoff smoother
// Filter state, configuration registers, shared multiplier and divider.
// ---------------------------------------------------------------------------
module acs_dp #(
  parameter int FRAC_BITS = acs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  acs_pkg::cmd_t      cmd,
  output acs_pkg::stat_t     stat,
  input  logic               req_type,
  input  logic signed [31:0] raw_x,
  input  logic signed [31:0] raw_y,
  input  logic signed [31:0] raw_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output logic signed [31:0] smooth_x,
  output logic signed [31:0] smooth_y,
  output logic signed [31:0] smooth_z
);
  import acs_pkg::*;

  // cutoff, product and divisor widths
  localparam int SH    = FRAC_BITS + 8;
  localparam int F_W   = 58 - SH;
  localparam int A_W   = (F_W > 33) ? F_W : 33;
  localparam int PR_W  = A_W + 32;
  localparam int P_W   = F_W + 16;
  localparam int WH_W  = F_W + 19;
  localparam int DV_W  = F_W + 20;

  logic [15:0]        jit, lag, per;
  logic [31:0]        pos [3];
  logic [31:0]        vel [3];
  logic [31:0]        raw [3];
  logic               upd;
  logic [31:0]        vraw;
  logic [F_W-1:0]     f;
  logic [PR_W-1:0]    prod;
  logic [15:0]        plo;
  logic [WH_W-1:0]    whi;
  logic [30:0]        alpha;

  logic [15:0]        per_eff;
  logic [31:0]        cur_pos, cur_vel, cur_raw, vel_mag;
  logic [32:0]        dif_c, mag_c, dv_c;
  logic               vel_blend;
  logic [32:0]        bl_prev, bl_d, bl_m, bl_t, bl_new;
  logic [PR_W-1:0]    rnd, fsh, mul_p;
  logic [A_W-1:0]     ma;
  logic [31:0]        mb;
  logic               div_start, div_busy;
  logic [63:0]        div_dvd, div_q;
  logic [DV_W-1:0]    div_dvs, dvs_c;
  logic [31:0]        vsat;

  assign per_eff = (per == 16'd0) ? 16'd1 : per;
  assign cur_pos = pos[cmd.axis];
  assign cur_vel = vel[cmd.axis];
  assign cur_raw = raw[cmd.axis];
  assign vel_mag = cur_vel[31] ? (32'd0 - cur_vel) : cur_vel;

  // raw minus filtered position
  assign dif_c = {cur_raw[31], cur_raw} - {cur_pos[31], cur_pos};
  assign mag_c = dif_c[32] ? (33'd0 - dif_c) : dif_c;
  assign dv_c  = {vraw[31], vraw} - {cur_vel[31], cur_vel};

  // blend: prev + sign * round(|d| * alpha / 2^30)
  assign vel_blend = (cmd.op == OP_VMUL) || (cmd.op == OP_VUPD);
  assign bl_prev   = vel_blend ? {cur_vel[31], cur_vel} : {cur_pos[31], cur_pos};
  assign bl_d      = vel_blend ? dv_c : dif_c;
  assign bl_m      = bl_d[32] ? (33'd0 - bl_d) : bl_d;
  assign rnd       = prod + (PR_W'(1) << 29);
  assign bl_t      = rnd[62:30];
  assign bl_new    = bl_d[32] ? (bl_prev - bl_t) : (bl_prev + bl_t);

  // cutoff velocity term and alpha divisor
  assign fsh   = prod >> SH;
  assign dvs_c = DV_W'(whi) + DV_W'(prod[34:16]) + (DV_W'(1) << 32);

  // velocity saturation
  always_comb begin
    if (dif_c[32]) begin
      vsat = (div_q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
    end else begin
      vsat = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_PMUL: begin
        ma = A_W'(f);
        mb = 32'(per_eff);
      end
      OP_WHI: begin
        ma = A_W'(prod[P_W-1:16]);
        mb = 32'(TWO_PI_Q16);
      end
      OP_WLO: begin
        ma = A_W'(plo);
        mb = 32'(TWO_PI_Q16);
      end
      OP_VMUL, OP_PMULB: begin
        ma = A_W'(bl_m);
        mb = 32'(alpha);
      end
      OP_LAGK: begin
        ma = A_W'(lag);
        mb = 32'(LAG_SCALE_Q24);
      end
      OP_FMUL: begin
        ma = A_W'(prod[33:8]);
        mb = vel_mag;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul_p = PR_W'(ma) * PR_W'(mb);

  // divider: velocity quotient or alpha complement
  assign div_start = (cmd.op == OP_DIFF) || (cmd.op == OP_WSUM);
  assign div_dvd   = (cmd.op == OP_DIFF) ? {15'd0, mag_c, 16'd0} : 64'h4000_0000_0000_0000;
  assign div_dvs   = (cmd.op == OP_DIFF) ? DV_W'(per_eff) : dvs_c;

  acs_div #(
    .DVS_W(DV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign stat.upd      = upd;
  assign stat.div_busy = div_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      jit <= JITTER_RST;
      lag <= LAG_RST;
      per <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_JITTER: jit <= cfg_wdata;
        REG_LAG:    lag <= cfg_wdata;
        REG_PERIOD: per <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '{default: '0};
      vel <= '{default: '0};
    end else begin
      case (cmd.op)
        OP_START: begin
          pos <= raw;
        end
        OP_VUPD: begin
          vel[cmd.axis] <= bl_new[31:0];
        end
        OP_PUPD: begin
          pos[cmd.axis] <= bl_new[31:0];
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        raw[0] <= raw_x;
        raw[1] <= raw_y;
        raw[2] <= raw_z;
        upd    <= req_type;
      end
      OP_VSAT:  vraw  <= vsat;
      OP_F1HZ:  f     <= F_W'(ONE_HZ_Q16);
      OP_FSET:  f     <= F_W'({jit, 8'd0}) + fsh[F_W-1:0];
      OP_ALPHA: alpha <= ALPHA_ONE - div_q[30:0];
      OP_PMUL, OP_VMUL, OP_PMULB, OP_LAGK, OP_FMUL: begin
        prod <= mul_p;
      end
      OP_WHI: begin
        plo  <= prod[15:0];
        prod <= mul_p;
      end
      OP_WLO: begin
        whi  <= prod[WH_W-1:0];
        prod <= mul_p;
      end
      OP_OUT: begin
        smooth_x <= pos[0];
        smooth_y <= pos[1];
        smooth_z <= pos[2];
      end
      default: ;
    endcase
  end
endmodule

// ----- sv/adaptive_cutoff_smoother_3axis_top.sv -----
// ---------------------------------------------------------------------------
// adaptive_cutoff_smoother_3axis_top: three-axis one-euro style smoother
// Controller, datapath and shared divider wired to the request, result and
// configuration ports.
// ---------------------------------------------------------------------------
// in_ch carries requests: req_type 0 loads the filtered position from
// raw_x/y/z, req_type 1 filters a new sample. Each request gives exactly one
// result on out_ch, the filtered position in signed Q16.16.
// Configuration: cfg_we with cfg_addr 0 jitter, 1 lag, 2 sample period; write
// only while no request is in flight.
// Timing: one request at a time. A start request passes the dispatch and
// output states after it is accepted. An update runs per axis three
// divisions on the one serial divider (velocity, 1 Hz alpha, position alpha)
// and the multiply and update steps around them, plus the dispatch and
// output states. The block is ready again in the same cycle that the result
// turns valid.
// Reset clears positions and velocities to zero and loads the register
// defaults. The finished result sits in an output register: the next request
// is taken while it waits, and a stalled receiver only holds the block at the
// end of that next request.
// ---------------------------------------------------------------------------
module adaptive_cutoff_smoother_3axis_top #(
  parameter int FRAC_BITS = acs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  acs_in_if.sink      in_ch,
  acs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import acs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  acs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath
  acs_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (in_ch.req_type),
    .raw_x     (in_ch.raw_x),
    .raw_y     (in_ch.raw_y),
    .raw_z     (in_ch.raw_z),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .smooth_x  (out_ch.smooth_x),
    .smooth_y  (out_ch.smooth_y),
    .smooth_z  (out_ch.smooth_z)
  );

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while another is in flight");

  // divider started only when free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIFF || cmd.op == OP_WSUM) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  // result appears only after the output copy
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.op == OP_OUT))
    else $error("result valid without output copy");
endmodule

// ----- sim/acs_tb_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acs_tb_if: testbench request kinds
// Named codes for the start and update requests used by the bench.
// ---------------------------------------------------------------------------
package acs_tb_types;
  // kinds of request
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;
endpackage

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for adaptive_cutoff_smoother_3axis_top
// Sends start and update requests through a queue-fed driver and collects
// the filtered results in a monitor. A fixed-point copy of the filter
// predicts each result. Both sides insert random gaps and stalls, and the
// registers are changed between phases, including their extreme values.
// ---------------------------------------------------------------------------
module testbench;
  import acs_pkg::*;
  import acs_tb_types::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic        kind;
    logic [31:0] x, y, z;
  } sample_t;

  typedef struct {
    logic [31:0] x, y, z;
  } smooth_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  acs_in_if  in_ch();
  acs_out_if out_ch();

  adaptive_cutoff_smoother_3axis_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  longint pos_q[3];
  longint vel_q[3];
  longint unsigned jitter_q, lag_q, period_q;

  sample_t pending_q[$];
  smooth_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int starts_sent = 0;
  int updates_sent = 0;
  int idle_cycles = 0;
  bit done_stim = 1'b0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned eff_period();
    return period_q == 0 ? 64'd1 : period_q;
  endfunction

  // smoothing factor in Q0.30 for a cutoff in unsigned Q.16
  function automatic longint unsigned smooth_alpha(longint unsigned f16);
    longint unsigned p, w, beta;
    p = f16 * eff_period();
    w = (p >> 16) * 64'(TWO_PI_Q16) + (((p & 64'hFFFF) * 64'(TWO_PI_Q16)) >> 16);
    beta = (64'd1 << 62) / (w + 64'h1_0000_0000);
    return 64'(ALPHA_ONE) - beta;
  endfunction

  function automatic longint mix(longint prev, longint cur, longint unsigned a);
    longint d;
    longint unsigned t;
    d = cur - prev;
    t = (mag(d) * a + (64'd1 << 29)) >> 30;
    return d < 0 ? prev - longint'(t) : prev + longint'(t);
  endfunction

  function automatic longint sample_velocity(longint raw, longint p);
    longint d;
    longint unsigned q;
    d = raw - p;
    q = (mag(d) << 16) / eff_period();
    if (d < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return longint'(q);
  endfunction

  // advance the filter for one request and return the filtered position
  function automatic smooth_t predict_smooth(sample_t s);
    smooth_t r;
    logic [31:0] raw_w[3];
    longint raw, v;
    longint unsigned lagk, f16;
    raw_w = '{s.x, s.y, s.z};
    for (int i = 0; i < 3; i++) begin
      raw = longint'(signed'(raw_w[i]));
      if (s.kind == REQ_START) begin
        pos_q[i] = raw;
      end else begin
        v = sample_velocity(raw, pos_q[i]);
        vel_q[i] = mix(vel_q[i], v, smooth_alpha(64'(ONE_HZ_Q16)));
        lagk = (lag_q * 64'(LAG_SCALE_Q24)) >> 8;
        f16 = (jitter_q << 8) + ((lagk * mag(vel_q[i])) >> (FRAC + 8));
        pos_q[i] = mix(pos_q[i], raw, smooth_alpha(f16));
      end
    end
    r.x = pos_q[0][31:0];
    r.y = pos_q[1][31:0];
    r.z = pos_q[2][31:0];
    return r;
  endfunction

  // driver: request channel
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.req_type <= 1'b0;
      in_ch.raw_x <= '0;
      in_ch.raw_y <= '0;
      in_ch.raw_z <= '0;
      in_gap <= 0;
    end else begin
      automatic bit fire = in_ch.valid && in_ch.ready;
      automatic bit busy = in_ch.valid && !in_ch.ready;
      if (fire) begin
        expected_q.push_back(predict_smooth(pending_q.pop_front()));
      end
      if (!busy) begin
        if (fire) begin
          in_gap <= gap_len();
          in_ch.valid <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.req_type <= pending_q[0].kind;
          in_ch.raw_x <= pending_q[0].x;
          in_ch.raw_y <= pending_q[0].y;
          in_ch.raw_z <= pending_q[0].z;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result channel with random stalls
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h %h %h", out_ch.smooth_x,
                     out_ch.smooth_y, out_ch.smooth_z);
        end else begin
          automatic smooth_t e = expected_q.pop_front();
          if (e.x !== out_ch.smooth_x || e.y !== out_ch.smooth_y ||
              e.z !== out_ch.smooth_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h %h %h actual %h %h %h", e.x, e.y, e.z,
                       out_ch.smooth_x, out_ch.smooth_y, out_ch.smooth_z);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else if (!done_stim || expected_q.size() > 0)
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired, %0d results outstanding", expected_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic set_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_JITTER: jitter_q = val;
      REG_LAG:    lag_q = val;
      REG_PERIOD: period_q = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< FRAC;
      default: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< 4;
    endcase
  endfunction

  task automatic add(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    sample_t s;
    s.kind = kind; s.x = x; s.y = y; s.z = z;
    pending_q.push_back(s);
    if (kind == REQ_START) starts_sent++; else updates_sent++;
  endtask

  // random phase: a start then a walk of updates, now and then a random request of either kind
  task automatic random_track(int n);
    logic [31:0] bx, by, bz;
    int mode;
    mode = $urandom_range(0, 2);
    bx = rand_pos(mode); by = rand_pos(mode); bz = rand_pos(mode);
    add(REQ_START, bx, by, bz);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        add(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
      end else begin
        bx = bx + 32'($signed($urandom_range(0, 8191)) - 4096) * (mode == 0 ? 4096 : 16);
        by = by + 32'($signed($urandom_range(0, 8191)) - 4096) * 16;
        bz = bz + 32'($signed($urandom_range(0, 255)) - 128) * 256;
        add(REQ_UPDATE, bx, by, bz);
      end
    end
  endtask

  // stimulus
  initial begin
    foreach (pos_q[i]) begin
      pos_q[i] = 0;
      vel_q[i] = 0;
    end
    jitter_q = JITTER_RST; lag_q = LAG_RST; period_q = PERIOD_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset defaults, zero difference, extremes, velocity saturation
    add(REQ_UPDATE, 32'h0, 32'h0, 32'h0);
    add(REQ_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    add(REQ_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add(REQ_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add(REQ_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555);
    add(REQ_START, 32'h0001_0000, 32'hFFFF_0000, 32'hAAAA_AAAA);
    add(REQ_UPDATE, 32'h0002_0000, 32'hFFFE_0000, 32'hAAAA_AAAA);
    drain();

    // zero period acts as one, extreme gains
    set_reg(REG_PERIOD, 16'h0000);
    set_reg(REG_JITTER, 16'hFFFF);
    set_reg(REG_LAG, 16'hFFFF);
    add(REQ_UPDATE, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0001);
    add(REQ_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    add(REQ_START, 32'h0, 32'h0, 32'h0);
    add(REQ_UPDATE, 32'hFFFF_FFFF, 32'h1, 32'h0);
    drain();
    set_reg(REG_PERIOD, 16'hFFFF);
    set_reg(REG_JITTER, 16'h0000);
    set_reg(REG_LAG, 16'h0000);
    add(REQ_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0F0F_0F0F);
    add(REQ_UPDATE, 32'h0, 32'h0, 32'hF0F0_F0F0);
    add(REQ_UPDATE, 32'h0, 32'h0, 32'hF0F0_F0F0);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin set_reg(REG_JITTER, 16'd205); set_reg(REG_LAG, 16'd205);
                 set_reg(REG_PERIOD, 16'd1966); end
        1: begin set_reg(REG_JITTER, 16'd1); set_reg(REG_LAG, 16'hFFFF);
                 set_reg(REG_PERIOD, 16'd1); end
        2: begin set_reg(REG_JITTER, 16'hFFFF); set_reg(REG_LAG, 16'd0);
                 set_reg(REG_PERIOD, 16'hFFFF); end
        default: begin set_reg(REG_JITTER, 16'($urandom()));
                 set_reg(REG_LAG, 16'($urandom()));
                 set_reg(REG_PERIOD, 16'($urandom_range(0, 65535))); end
      endcase
      for (int t = 0; t < 3; t++) random_track(21);
      drain();
    end
    done_stim = 1'b1;
    repeat (50) @(posedge clk);

    $display("sent %0d start and %0d update requests, checked %0d results",
             starts_sent, updates_sent, results_seen);
    $display("registers swept over extremes, zero period and random values");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule
